[src/multi_servo_slew_limiter_top_macros.svh]
// Assertion macros for the servo slew limiter checker
`ifndef MULTI_SERVO_SLEW_LIMITER_TOP_MACROS_SVH
`define MULTI_SERVO_SLEW_LIMITER_TOP_MACROS_SVH
// assert an implication each clock edge outside reset
`define MSL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// assert an implication in the following cycle
`define MSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/msl_pkg.sv]
// ----------------------------------------------------------------------------
// msl_pkg
// Shared types and constants of the multi-servo slew limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package msl_pkg;
  localparam int NumServos = 8;
  localparam int IdW = (NumServos > 1) ? $clog2(NumServos) : 1;
  localparam logic [4:0] SpeedMax = 5'd20;
  localparam logic [4:0] SpeedMin = 5'd1;

  typedef enum logic [2:0] {
    KIND_DEFINE   = 3'd0,
    KIND_MOVE_TO  = 3'd1,
    KIND_SET_SPD  = 3'd2,
    KIND_STOP_ALL = 3'd3,
    KIND_HOME_ALL = 3'd4,
    KIND_HOME_ONE = 3'd5,
    KIND_TICK     = 3'd6,
    KIND_NONE     = 3'd7
  } kind_e;

  // request to the pulse mapper
  typedef struct packed {
    logic        start;
    logic [7:0]  angle;
    logic [7:0]  lo_ang;
    logic [7:0]  hi_ang;
    logic [15:0] lo_pls;
    logic [15:0] hi_pls;
  } map_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] pulse;
  } map_rsp_t;

  function automatic logic [4:0] clamp_speed(input logic [7:0] s);
    if (s < 8'(SpeedMin)) return SpeedMin;
    if (s > 8'(SpeedMax)) return SpeedMax;
    return s[4:0];
  endfunction
endpackage

[src/msl_pulse_map.sv]
// ----------------------------------------------------------------------------
// msl_pulse_map
// Rounded linear angle-to-pulse map with a shared multiplier step and a
// restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module msl_pulse_map (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msl_pkg::map_req_t req_i,
  output msl_pkg::map_rsp_t rsp_o
);
  import msl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } st_e;

  localparam int NW = 28;  // |2*num+den| < 2^27
  st_e          st_q, st_d;
  logic [4:0]   cnt_q, cnt_d;
  logic         neg_q, neg_d, zero_q, zero_d, done_q, done_d;
  logic signed [8:0]  da_q, da_d, den_q, den_d;
  logic signed [16:0] dp_q, dp_d;
  logic [15:0]  lo_q, lo_d, pls_q, pls_d;
  logic [NW-1:0] t_q, t_d, quo_q, quo_d;
  logic [NW:0]   rem_q, rem_d;
  logic [9:0]    d2_q, d2_d;
  logic signed [25:0] prod;
  logic signed [27:0] tt;
  logic [NW:0]   trial;
  logic signed [NW+1:0] q_s, r_s;

  always_comb begin
    prod  = da_q * dp_q;
    tt    = 28'(2 * 28'(prod)) + 28'(den_q);
    trial = {rem_q[NW-1:0], t_q[NW-1]};
    q_s   = neg_q ? -($signed({2'b00, quo_q}) + ((rem_q != '0) ? 30'sd1 : 30'sd0))
                  : $signed({2'b00, quo_q});
    r_s   = $signed({14'd0, lo_q}) + q_s;
  end

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; neg_d = neg_q; zero_d = zero_q; done_d = 1'b0;
    da_d = da_q; den_d = den_q; dp_d = dp_q; lo_d = lo_q; pls_d = pls_q;
    t_d = t_q; quo_d = quo_q; rem_d = rem_q; d2_d = d2_q;
    unique case (st_q)
      S_IDLE: if (req_i.start) begin
        da_d  = $signed({1'b0, req_i.angle}) - $signed({1'b0, req_i.lo_ang});
        den_d = $signed({1'b0, req_i.hi_ang}) - $signed({1'b0, req_i.lo_ang});
        dp_d  = $signed({1'b0, req_i.hi_pls}) - $signed({1'b0, req_i.lo_pls});
        lo_d  = req_i.lo_pls;
        zero_d = (req_i.hi_ang == req_i.lo_ang);
        // fold the divisor sign into the numerator
        if (req_i.hi_ang < req_i.lo_ang) begin
          da_d  = -($signed({1'b0, req_i.angle}) - $signed({1'b0, req_i.lo_ang}));
          den_d = $signed({1'b0, req_i.lo_ang}) - $signed({1'b0, req_i.hi_ang});
        end
        st_d = S_MUL;
      end
      S_MUL: begin
        neg_d = tt[27];
        t_d   = tt[27] ? NW'(-tt) : NW'(tt);
        d2_d  = {den_q, 1'b0};
        quo_d = '0; rem_d = '0; cnt_d = '0;
        st_d  = zero_q ? S_FIN : S_DIV;
      end
      S_DIV: begin
        t_d = {t_q[NW-2:0], 1'b0};
        if (trial >= (NW+1)'(d2_q)) begin
          rem_d = trial - (NW+1)'(d2_q);
          quo_d = {quo_q[NW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[NW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(NW-1)) st_d = S_FIN;
      end
      S_FIN: begin
        if (zero_q)              pls_d = lo_q;
        else if (r_s < 0)        pls_d = '0;
        else if (r_s > 30'sd65535) pls_d = 16'hFFFF;
        else                     pls_d = r_s[15:0];
        done_d = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      st_q <= st_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d; zero_q <= zero_d; da_q <= da_d; den_q <= den_d; dp_q <= dp_d;
    lo_q <= lo_d; pls_q <= pls_d; t_q <= t_d; quo_q <= quo_d; rem_q <= rem_d;
    d2_q <= d2_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.pulse = pls_q;
endmodule

[src/multi_servo_slew_limiter_top.sv]
// ----------------------------------------------------------------------------
// multi_servo_slew_limiter_top
// Servo table with slew limiting and a rounded linear pulse map.
// ----------------------------------------------------------------------------
// Usage: drive a command on the input ports and raise start while busy
// is low; the word is taken on that edge. Results come out one cycle wide
// on valid_o, last_o marks the final word of a command. The receiver
// cannot stall, so every result is taken when shown.
// Flow: set speed, stop-free invalid and unused commands go from the
// accepting edge straight to their acknowledgement; single moves first
// pass the walk state, broadcasts walk the whole table. Define and each
// moved servo of a tick run the pulse mapper: a request, then capture,
// multiply, 28 restoring divide steps, saturate and done in the mapper,
// then an emit step. A tick first walks the table one entry per cycle,
// then maps each moved servo in table order. A define of a valid servo
// shows its pulse first and its acknowledgement after it.
// Reset clears the whole servo table and the sequencer at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module multi_servo_slew_limiter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  servo_id_i,
  input  logic [7:0]  angle_i,
  input  logic [7:0]  speed_i,
  input  logic [7:0]  min_angle_i,
  input  logic [7:0]  max_angle_i,
  input  logic [15:0] min_pulse_us_i,
  input  logic [15:0] max_pulse_us_i,
  input  logic [3:0]  channel_i,
  output logic        valid_o,
  output logic        is_pulse_o,
  output logic        accepted_o,
  output logic [7:0]  out_servo_o,
  output logic [3:0]  out_channel_o,
  output logic [15:0] pulse_us_o,
  output logic [7:0]  current_angle_o,
  output logic [7:0]  target_angle_o,
  output logic [4:0]  step_speed_o,
  output logic        moving_o,
  output logic        any_moving_o,
  output logic        last_o
);
  import msl_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WALK  = 7'b0000010,
    S_TICK  = 7'b0000100,
    S_MAP   = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_EMITP = 7'b0100000,
    S_ACK   = 7'b1000000
  } st_e;

  logic [7:0]  cur_q [NumServos], tgt_q [NumServos], lo_a_q [NumServos];
  logic [7:0]  hi_a_q [NumServos], home_q [NumServos];
  logic [15:0] lo_p_q [NumServos], hi_p_q [NumServos];
  logic [4:0]  spd_q [NumServos];
  logic [3:0]  chn_q [NumServos];
  logic [NumServos-1:0] mov_q, moved_q;

  st_e        st_q;
  kind_e      kind_q;
  logic [7:0] sid_q, ang_q;
  logic [IdW:0] idx_q;
  logic       valid_q;
  logic [IdW-1:0] id;
  logic [IdW-1:0] ix;
  logic       more;
  logic       out_v_q;
  map_req_t   mreq;
  map_rsp_t   mrsp;
  logic [7:0] clamp_a;
  logic [7:0] mv_a;

  assign id  = valid_q ? sid_q[IdW-1:0] : '0;
  assign ix  = idx_q[IdW-1:0];
  assign busy = (st_q != S_IDLE);

  // clamp helper for move commands on the walking index or the addressed id
  function automatic logic [7:0] clampf(input logic [7:0] a, input logic [7:0] lo,
                                        input logic [7:0] hi);
    if (a < lo) return lo;
    if (a > hi) return hi;
    return a;
  endfunction

  assign mv_a    = (kind_q == KIND_MOVE_TO) ? ang_q : home_q[id];
  assign clamp_a = clampf(mv_a, lo_a_q[id], hi_a_q[id]);

  always_comb begin
    mreq.start  = (st_q == S_MAP);
    mreq.angle  = cur_q[ix];
    mreq.lo_ang = lo_a_q[ix];
    mreq.hi_ang = hi_a_q[ix];
    mreq.lo_pls = lo_p_q[ix];
    mreq.hi_pls = hi_p_q[ix];
  end

  msl_pulse_map u_map (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(mreq), .rsp_o(mrsp));

  // any moved servo still left after the current index
  always_comb begin
    more = 1'b0;
    for (int k = 0; k < NumServos; k++)
      if ((IdW+1)'(k) > idx_q && moved_q[k]) more = 1'b1;
  end

  logic [7:0] d_ang, tc;
  logic [8:0] dmag;
  always_comb begin
    dmag = (tgt_q[ix] >= cur_q[ix]) ? 9'(tgt_q[ix] - cur_q[ix])
                                     : 9'(cur_q[ix] - tgt_q[ix]);
    tc   = (tgt_q[ix] > cur_q[ix]) ? cur_q[ix] + 8'(spd_q[ix])
                                    : cur_q[ix] - 8'(spd_q[ix]);
    d_ang = tc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; out_v_q <= 1'b0; mov_q <= '0; moved_q <= '0; idx_q <= '0;
      kind_q <= KIND_NONE; sid_q <= '0; ang_q <= '0; valid_q <= 1'b0;
      for (int k = 0; k < NumServos; k++) begin
        cur_q[k] <= '0; tgt_q[k] <= '0; lo_a_q[k] <= '0; hi_a_q[k] <= '0;
        home_q[k] <= '0; lo_p_q[k] <= '0; hi_p_q[k] <= '0; spd_q[k] <= '0;
        chn_q[k] <= '0;
      end
    end else begin
      out_v_q <= 1'b0;
      unique case (st_q)
        S_IDLE: if (start) begin
          kind_q  <= kind_e'(kind_i);
          sid_q   <= servo_id_i;
          ang_q   <= angle_i;
          valid_q <= (servo_id_i < 8'(NumServos));
          idx_q   <= '0;
          st_q    <= S_ACK;
          if (servo_id_i < 8'(NumServos)) begin
            unique case (kind_e'(kind_i))
              KIND_DEFINE: begin
                lo_a_q[servo_id_i[IdW-1:0]] <= min_angle_i;
                hi_a_q[servo_id_i[IdW-1:0]] <= max_angle_i;
                lo_p_q[servo_id_i[IdW-1:0]] <= min_pulse_us_i;
                hi_p_q[servo_id_i[IdW-1:0]] <= max_pulse_us_i;
                chn_q[servo_id_i[IdW-1:0]]  <= channel_i;
                home_q[servo_id_i[IdW-1:0]] <= angle_i;
                cur_q[servo_id_i[IdW-1:0]]  <= angle_i;
                tgt_q[servo_id_i[IdW-1:0]]  <= angle_i;
                mov_q[servo_id_i[IdW-1:0]]  <= 1'b0;
                spd_q[servo_id_i[IdW-1:0]]  <= clamp_speed(speed_i);
                idx_q <= (IdW+1)'(servo_id_i[IdW-1:0]);
                st_q  <= S_MAP;
              end
              KIND_SET_SPD: spd_q[servo_id_i[IdW-1:0]] <= clamp_speed(speed_i);
              default: ;
            endcase
          end
          unique case (kind_e'(kind_i))
            KIND_STOP_ALL, KIND_HOME_ALL: st_q <= S_WALK;
            KIND_TICK: begin
              moved_q <= mov_q;
              st_q    <= S_TICK;
            end
            KIND_DEFINE: if (servo_id_i >= 8'(NumServos)) st_q <= S_ACK;
            default: ;
          endcase
          if ((kind_e'(kind_i) == KIND_MOVE_TO || kind_e'(kind_i) == KIND_HOME_ONE)
              && servo_id_i < 8'(NumServos))
            st_q <= S_WALK;
        end
        S_WALK: begin
          // one table entry per cycle for broadcasts, one for single moves
          if (kind_q == KIND_STOP_ALL) begin
            tgt_q[ix] <= cur_q[ix];
            mov_q[ix] <= 1'b0;
          end else if (kind_q == KIND_HOME_ALL) begin
            tgt_q[ix] <= clampf(home_q[ix], lo_a_q[ix], hi_a_q[ix]);
            mov_q[ix] <= (cur_q[ix] != clampf(home_q[ix], lo_a_q[ix], hi_a_q[ix]));
          end else begin
            tgt_q[id] <= clamp_a;
            mov_q[id] <= (cur_q[id] != clamp_a);
          end
          idx_q <= idx_q + 1'b1;
          if (kind_q != KIND_STOP_ALL && kind_q != KIND_HOME_ALL) st_q <= S_ACK;
          else if (idx_q == (IdW+1)'(NumServos - 1)) st_q <= S_ACK;
        end
        S_TICK: begin
          if (mov_q[ix]) begin
            if (dmag <= 9'(spd_q[ix])) begin
              cur_q[ix] <= tgt_q[ix];
              mov_q[ix] <= 1'b0;
            end else cur_q[ix] <= d_ang;
          end
          if (idx_q == (IdW+1)'(NumServos - 1)) begin
            if (moved_q == '0) st_q <= S_IDLE;
            else begin
              idx_q <= '0;
              st_q  <= moved_q[0] ? S_MAP : S_EMITP;
            end
          end else idx_q <= idx_q + 1'b1;
        end
        S_MAP:  st_q <= S_WAIT;
        S_WAIT: if (mrsp.done) begin
          out_v_q <= 1'b1;
          st_q    <= S_EMITP;
        end
        S_EMITP: begin
          // skip to the next moved servo, or finish; a define goes on to its acknowledgement
          if (kind_q == KIND_DEFINE) st_q <= S_ACK;
          else if (!more) st_q <= S_IDLE;
          else begin
            idx_q <= idx_q + 1'b1;
            st_q  <= moved_q[ix + 1'b1] ? S_MAP : S_EMITP;
          end
        end
        S_ACK: begin
          if (!out_v_q) begin
            out_v_q <= 1'b1;
            st_q    <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // result register
  logic        is_p_q, acc_q, last_q, mv_q, any_q;
  logic [7:0]  osv_q, oca_q, ota_q;
  logic [3:0]  och_q;
  logic [15:0] opl_q;
  logic [4:0]  osp_q;
  logic        pulse_evt, ack_evt;
  logic [IdW-1:0] rix;

  assign pulse_evt = (st_q == S_WAIT) && mrsp.done;
  assign ack_evt   = (st_q == S_ACK) && !out_v_q;
  assign rix       = pulse_evt ? ix : id;

  always_ff @(posedge clk_i) begin
    if (pulse_evt || ack_evt) begin
      is_p_q <= pulse_evt;
      acc_q  <= pulse_evt ? 1'b1 : (valid_q && kind_q != KIND_TICK && kind_q != KIND_NONE);
      osv_q  <= pulse_evt ? 8'(ix) : sid_q;
      opl_q  <= pulse_evt ? mrsp.pulse : 16'd0;
      last_q <= pulse_evt ? (kind_q == KIND_TICK && !more) : 1'b1;
      any_q  <= (mov_q != '0);
      if (pulse_evt || (valid_q && kind_q != KIND_NONE)) begin
        och_q <= chn_q[rix]; oca_q <= cur_q[rix]; ota_q <= tgt_q[rix];
        osp_q <= spd_q[rix]; mv_q <= mov_q[rix];
      end else begin
        och_q <= '0; oca_q <= '0; ota_q <= '0; osp_q <= '0; mv_q <= 1'b0;
      end
    end
  end

  assign valid_o = out_v_q;
  assign is_pulse_o = is_p_q;
  assign accepted_o = acc_q;
  assign out_servo_o = osv_q;
  assign out_channel_o = och_q;
  assign pulse_us_o = opl_q;
  assign current_angle_o = oca_q;
  assign target_angle_o = ota_q;
  assign step_speed_o = osp_q;
  assign moving_o = mv_q;
  assign any_moving_o = any_q;
  assign last_o = last_q;
endmodule

[src/msl_checker.sv]
// ----------------------------------------------------------------------------
// msl_checker
// Port-level checks on the servo slew limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_servo_slew_limiter_top_macros.svh"
module msl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       valid_o,
  input logic       is_pulse_o,
  input logic       accepted_o,
  input logic       last_o,
  input logic [4:0] step_speed_o
);
  // a taken word makes the block busy
  `MSL_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  // pulse updates are always accepted
  `MSL_ASSERT_IMPL(a_pulse_acc, clk_i, rst_ni, valid_o && is_pulse_o, accepted_o)
  // acknowledgements close their command
  `MSL_ASSERT_IMPL(a_ack_last, clk_i, rst_ni, valid_o && !is_pulse_o, last_o)
  // speed never exceeds its clamp
  `MSL_ASSERT_IMPL(a_speed, clk_i, rst_ni, valid_o, step_speed_o <= 5'd20)
endmodule

bind multi_servo_slew_limiter_top msl_checker u_msl_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .valid_o(valid_o),
  .is_pulse_o(is_pulse_o), .accepted_o(accepted_o), .last_o(last_o),
  .step_speed_o(step_speed_o)
);

[dv/tb_multi_servo_slew_limiter_top.sv]
// ----------------------------------------------------------------------------
// tb_multi_servo_slew_limiter_top
// Self-checking bench for the servo slew limiter: a scoreboard predicts the
// acknowledgement and pulse words of every command taken by the block and
// matches them in order against the words seen on valid_o.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_multi_servo_slew_limiter_top;
  import msl_pkg::*;

  localparam int NumItems  = 330;
  localparam int IdleLimit = 5000;
  localparam int DrainWait = 300;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  servo_id;
    logic [7:0]  angle;
    logic [7:0]  speed;
    logic [7:0]  min_angle;
    logic [7:0]  max_angle;
    logic [15:0] min_pulse;
    logic [15:0] max_pulse;
    logic [3:0]  channel;
  } servo_cmd_t;

  localparam int CmdW = $bits(servo_cmd_t);

  typedef struct packed {
    logic        is_pulse;
    logic        accepted;
    logic [7:0]  servo;
    logic [3:0]  channel;
    logic [15:0] pulse;
    logic [7:0]  cur_angle;
    logic [7:0]  tgt_angle;
    logic [4:0]  speed;
    logic        moving;
    logic        any_moving;
    logic        last;
  } servo_word_t;

  class servo_scoreboard;
    servo_word_t expected_q[$];
    int          errors;
    logic [7:0]  cur[NumServos];
    logic [7:0]  tgt[NumServos];
    logic [4:0]  spd[NumServos];
    logic        mov[NumServos];
    logic [7:0]  lo_ang[NumServos];
    logic [7:0]  hi_ang[NumServos];
    logic [15:0] lo_pls[NumServos];
    logic [15:0] hi_pls[NumServos];
    logic [7:0]  home[NumServos];
    logic [3:0]  chan[NumServos];

    function new();
      errors = 0;
      for (int i = 0; i < NumServos; i++) begin
        cur[i] = '0; tgt[i] = '0; spd[i] = '0; mov[i] = 1'b0;
        lo_ang[i] = '0; hi_ang[i] = '0; lo_pls[i] = '0; hi_pls[i] = '0;
        home[i] = '0; chan[i] = '0;
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function logic [4:0] limit_speed(logic [7:0] s);
      if (s < 8'd1) return 5'd1;
      if (s > 8'd20) return 5'd20;
      return s[4:0];
    endfunction

    function logic [7:0] limit_angle(int id, logic [7:0] a);
      if (a < lo_ang[id]) return lo_ang[id];
      if (a > hi_ang[id]) return hi_ang[id];
      return a;
    endfunction

    // rounded linear map, halves toward plus infinity, saturated to 16 bits
    function logic [15:0] angle_pulse(int id, logic [7:0] a);
      longint den, num, t, d2, q, r;
      den = longint'(hi_ang[id]) - longint'(lo_ang[id]);
      if (den == 0) return lo_pls[id];
      num = (longint'(a) - longint'(lo_ang[id])) *
            (longint'(hi_pls[id]) - longint'(lo_pls[id]));
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      t  = 2 * num + den;
      d2 = 2 * den;
      if (t >= 0) q = t / d2;
      else q = -((-t + d2 - 1) / d2);
      r = longint'(lo_pls[id]) + q;
      if (r < 0) r = 0;
      if (r > 65535) r = 65535;
      return r[15:0];
    endfunction

    function servo_word_t make_word(logic is_pulse, logic acc, logic [7:0] servo,
                                    logic valid, int id, logic [15:0] pulse);
      servo_word_t w;
      w.is_pulse   = is_pulse;
      w.accepted   = acc;
      w.servo      = servo;
      w.channel    = valid ? chan[id] : '0;
      w.pulse      = pulse;
      w.cur_angle  = valid ? cur[id] : '0;
      w.tgt_angle  = valid ? tgt[id] : '0;
      w.speed      = valid ? spd[id] : '0;
      w.moving     = valid ? mov[id] : 1'b0;
      w.any_moving = 1'b0;
      for (int i = 0; i < NumServos; i++) w.any_moving |= mov[i];
      w.last       = 1'b1;
      return w;
    endfunction

    function void aim(int id, logic [7:0] a);
      tgt[id] = limit_angle(id, a);
      mov[id] = (cur[id] != tgt[id]);
    endfunction

    function void note_command(servo_cmd_t c);
      servo_word_t w;
      servo_word_t pulses[$];
      logic        valid;
      int          id;
      int          d;
      int          mag;
      logic        moved[NumServos];
      valid = c.servo_id < NumServos;
      id    = valid ? int'(c.servo_id) : 0;
      case (kind_e'(c.kind))
        KIND_DEFINE: begin
          if (valid) begin
            lo_ang[id] = c.min_angle; hi_ang[id] = c.max_angle;
            lo_pls[id] = c.min_pulse; hi_pls[id] = c.max_pulse;
            chan[id] = c.channel; home[id] = c.angle;
            cur[id] = c.angle; tgt[id] = c.angle; mov[id] = 1'b0;
            spd[id] = limit_speed(c.speed);
            w = make_word(1'b1, 1'b1, 8'(id), 1'b1, id, angle_pulse(id, c.angle));
            w.last = 1'b0;
            expected_q.push_back(w);
          end
        end
        KIND_MOVE_TO:  if (valid) aim(id, c.angle);
        KIND_SET_SPD:  if (valid) spd[id] = limit_speed(c.speed);
        KIND_STOP_ALL: begin
          for (int i = 0; i < NumServos; i++) begin
            tgt[i] = cur[i];
            mov[i] = 1'b0;
          end
        end
        KIND_HOME_ALL: for (int i = 0; i < NumServos; i++) aim(i, home[i]);
        KIND_HOME_ONE: if (valid) aim(id, home[id]);
        KIND_TICK: begin
          for (int i = 0; i < NumServos; i++) begin
            moved[i] = mov[i];
            if (mov[i]) begin
              d   = int'(tgt[i]) - int'(cur[i]);
              mag = (d < 0) ? -d : d;
              if (mag <= int'(spd[i])) begin
                cur[i] = tgt[i];
                mov[i] = 1'b0;
              end else begin
                cur[i] = 8'(int'(cur[i]) + ((d > 0) ? int'(spd[i]) : -int'(spd[i])));
              end
            end
          end
          for (int i = 0; i < NumServos; i++) begin
            if (moved[i]) begin
              w = make_word(1'b1, 1'b1, 8'(i), 1'b1, i, angle_pulse(i, cur[i]));
              w.last = 1'b0;
              pulses.push_back(w);
            end
          end
          if (pulses.size() > 0) pulses[pulses.size() - 1].last = 1'b1;
          foreach (pulses[k]) expected_q.push_back(pulses[k]);
          return;
        end
        default: begin
          expected_q.push_back(make_word(1'b0, 1'b0, c.servo_id, 1'b0, 0, '0));
          return;
        end
      endcase
      expected_q.push_back(make_word(1'b0, valid, c.servo_id, valid, id, '0));
    endfunction

    task check_word(servo_word_t got);
      servo_word_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word servo=%0d pulse=%0d",
                                  got.servo, got.pulse));
        return;
      end
      e = expected_q.pop_front();
      if (got !== e)
        report_mismatch($sformatf({"got  p%0b a%0b s%0d ch%0d us%0d cur%0d tgt%0d",
          " spd%0d mv%0b any%0b l%0b / exp p%0b a%0b s%0d ch%0d us%0d cur%0d",
          " tgt%0d spd%0d mv%0b any%0b l%0b"},
          got.is_pulse, got.accepted, got.servo, got.channel, got.pulse,
          got.cur_angle, got.tgt_angle, got.speed, got.moving, got.any_moving,
          got.last, e.is_pulse, e.accepted, e.servo, e.channel, e.pulse,
          e.cur_angle, e.tgt_angle, e.speed, e.moving, e.any_moving, e.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  servo_cmd_t  cmd = '0;
  logic        valid_o, is_pulse_o, accepted_o, moving_o, any_moving_o, last_o;
  logic [7:0]  out_servo_o, current_angle_o, target_angle_o;
  logic [3:0]  out_channel_o;
  logic [15:0] pulse_us_o;
  logic [4:0]  step_speed_o;

  servo_scoreboard sb = new();
  int              idle_cycles = 0;

  multi_servo_slew_limiter_top i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .kind_i(cmd.kind), .servo_id_i(cmd.servo_id), .angle_i(cmd.angle),
    .speed_i(cmd.speed), .min_angle_i(cmd.min_angle), .max_angle_i(cmd.max_angle),
    .min_pulse_us_i(cmd.min_pulse), .max_pulse_us_i(cmd.max_pulse),
    .channel_i(cmd.channel),
    .valid_o, .is_pulse_o, .accepted_o, .out_servo_o, .out_channel_o, .pulse_us_o,
    .current_angle_o, .target_angle_o, .step_speed_o, .moving_o, .any_moving_o,
    .last_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // match every word shown by the block
  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      sb.check_word({is_pulse_o, accepted_o, out_servo_o, out_channel_o, pulse_us_o,
                     current_angle_o, target_angle_o, step_speed_o, moving_o,
                     any_moving_o, last_o});
  end

  always @(posedge clk_i) begin
    if (!rst_ni || valid_o || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task send_cmd(servo_cmd_t c);
    @(negedge clk_i);
    cmd   = c;
    start = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    sb.note_command(c);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  function automatic servo_cmd_t cmd_of(kind_e k, int id, int a = 0, int s = 0);
    servo_cmd_t c;
    c = '0;
    c.kind = k; c.servo_id = 8'(id); c.angle = 8'(a); c.speed = 8'(s);
    return c;
  endfunction

  function automatic servo_cmd_t define_of(int id, int a, int s, int lo, int hi,
                                           int plo, int phi, int ch);
    servo_cmd_t c;
    c = cmd_of(KIND_DEFINE, id, a, s);
    c.min_angle = 8'(lo); c.max_angle = 8'(hi);
    c.min_pulse = 16'(plo); c.max_pulse = 16'(phi); c.channel = 4'(ch);
    return c;
  endfunction

  function automatic servo_cmd_t random_cmd();
    servo_cmd_t c;
    int         r;
    c = servo_cmd_t'(CmdW'({$urandom, $urandom, $urandom}));
    r = $urandom_range(0, 99);
    if (r < 12) c.kind = KIND_DEFINE;
    else if (r < 34) c.kind = KIND_MOVE_TO;
    else if (r < 42) c.kind = KIND_SET_SPD;
    else if (r < 46) c.kind = KIND_STOP_ALL;
    else if (r < 52) c.kind = KIND_HOME_ALL;
    else if (r < 60) c.kind = KIND_HOME_ONE;
    else if (r < 98) c.kind = KIND_TICK;
    else c.kind = KIND_NONE;
    if ($urandom_range(0, 99) < 85) c.servo_id = 8'($urandom_range(0, NumServos - 1));
    // keep most limits ordered with sane pulse spans
    if (c.kind == KIND_DEFINE && $urandom_range(0, 99) < 70) begin
      c.min_angle = 8'($urandom_range(0, 100));
      c.max_angle = 8'($urandom_range(101, 255));
      c.angle     = 8'($urandom_range(c.min_angle, c.max_angle));
      c.min_pulse = 16'($urandom_range(400, 1000));
      c.max_pulse = 16'($urandom_range(1800, 2600));
      c.speed     = 8'($urandom_range(0, 24));
    end
    if (c.kind == KIND_SET_SPD && $urandom_range(0, 3) != 0)
      c.speed = 8'($urandom_range(0, 24));
    return c;
  endfunction

  initial begin
    servo_cmd_t directed_q[$];
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_q = '{
      define_of(0, 90, 5, 0, 180, 500, 2500, 0),
      define_of(1, 255, 0, 255, 0, 65535, 0, 15),     // reversed limits
      define_of(2, 40, 255, 40, 40, 1234, 4321, 5),   // equal limits
      define_of(3, 250, 20, 10, 20, 0, 65535, 9),     // home outside limits
      define_of(200, 1, 1, 0, 1, 1, 1, 1),            // bad id
      define_of(7, 0, 1, 0, 255, 1000, 2000, 3),
      cmd_of(KIND_MOVE_TO, 0, 180), cmd_of(KIND_MOVE_TO, 1, 0),
      cmd_of(KIND_MOVE_TO, 7, 255), cmd_of(KIND_MOVE_TO, 9, 20),
      cmd_of(KIND_MOVE_TO, 3, 0),
      cmd_of(KIND_SET_SPD, 0, 0, 0), cmd_of(KIND_SET_SPD, 0, 0, 255),
      cmd_of(KIND_SET_SPD, 250, 0, 7),
      cmd_of(KIND_TICK, 0), cmd_of(KIND_TICK, 0),
      cmd_of(KIND_STOP_ALL, 3), cmd_of(KIND_HOME_ALL, 100),
      cmd_of(KIND_HOME_ONE, 0), cmd_of(KIND_TICK, 0),
      cmd_of(KIND_NONE, 255), cmd_of(KIND_HOME_ONE, 255), cmd_of(KIND_TICK, 0),
      cmd_of(KIND_TICK, 0)
    };
    foreach (directed_q[k]) send_cmd(directed_q[k]);

    for (int n = 0; n < NumItems; n++) begin
      // quiet stretch in the middle: back-to-back words
      if ((n < 100 || n > 180) && $urandom_range(0, 99) < 35)
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      send_cmd(random_cmd());
    end

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
